/* sv/tsfc_pkg.sv */
// Shared constants and codes for the touch sample filter and calibrator.
package tsfc_pkg;

  // Samples per group and the trimmed-mean divisor
  localparam int SAMPLES = 5;
  localparam int DIV     = (SAMPLES > 2) ? (SAMPLES - 2) : 1;
  localparam int POS_W   = $clog2(SAMPLES);

  // Divide by DIV as multiply by a rounded-up reciprocal, exact for 16-bit numerators
  localparam int QSHIFT  = 16 + $clog2(DIV);
  localparam int RECIP_W = QSHIFT + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << QSHIFT) + DIV - 1) / DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];
  localparam int PROD_W  = 16 + RECIP_W;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int COORD_W  = 16;
  localparam int GAIN_W   = 18;
  localparam int OFF_W    = 16;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W   = 14;

  // Input kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_PEN_UP = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  // Group order within one scan
  localparam logic [1:0] GRP_X1 = 2'd0;
  localparam logic [1:0] GRP_Y1 = 2'd1;
  localparam logic [1:0] GRP_X2 = 2'd2;
  localparam logic [1:0] GRP_Y2 = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd5;

  localparam logic [SAMPLE_W-1:0] TOL_RESET  = 12'd50;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
  localparam logic [COORD_W-1:0]  COORD_MAX  = 16'hFFFF;

endpackage

/* sv/tsfc_scale.sv */
// Gain and offset calibration of one axis: registered multiply, then add and clamp.
module tsfc_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]     raw,
  input  logic signed [tsfc_pkg::GAIN_W-1:0] gain,
  input  logic signed [tsfc_pkg::OFF_W-1:0]  offset,
  output logic [tsfc_pkg::COORD_W-1:0]      coord
);
  import tsfc_pkg::*;

  localparam int P_W = GAIN_W + SAMPLE_W + 1;
  localparam int V_W = P_W + 1;

  logic signed [P_W-1:0] prod_r;
  logic signed [V_W-1:0] v;
  logic signed [V_W-1:0] off_scaled;

  // Product of gain and the unsigned raw value
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= P_W'(gain) * P_W'($signed({1'b0, raw}));
    end
  end

  // Add offset in Q.14, drop fraction, clamp to 0..65535
  assign off_scaled = V_W'(offset) <<< FRAC_W;
  assign v = V_W'(prod_r) + off_scaled;

  always_comb begin
    if (v[V_W-1]) begin
      coord = '0;
    end else if (|v[V_W-2:FRAC_W+COORD_W]) begin
      coord = COORD_MAX;
    end else begin
      coord = v[FRAC_W+COORD_W-1:FRAC_W];
    end
  end

endmodule

/* sv/touch_sample_filter_calibrator.sv */
// Top level: touch sample trimmed-mean filter, agreement check, calibration, press tracking.
//
// Usage: items enter on the in_ channel (in_valid/in_stall) as a kind and a 12-bit
// sample. Pen-down samples come in groups of SAMPLES: X, Y, X, Y. Each sample updates a
// running sum, min and max in the cycle it is accepted; one beat per cycle unless stalled.
// The last sample of the fourth group, a pen-up beat and an acknowledge beat each give
// one result beat on the out_ channel (out_valid/out_stall); other samples give none.
// After acceptance a beat moves through registered steps in order: numerator subtract,
// reciprocal multiply for the divide, agreement compare and average, gain multiply,
// then offset add, clamp and press-flag update into the output register. Throughput is one
// beat per cycle while the receiver does not stall; each stage has its own valid bit and
// moves when the stage after it is empty or moving, so bubbles are squeezed out.
// When the receiver stalls, the output beat holds and the pipe fills; in_stall rises only
// once no stage can move. Reset (rst_n low, synchronous) empties the pipe, clears the
// scan, sets tolerance to 50, gains and offsets to 0 and clears coordinates and flags.
// The user must write the cfg_ port registers while idle; the block does not enforce it.
module touch_sample_filter_calibrator (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsfc_pkg::CFG_W-1:0]        cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]     in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tsfc_pkg::COORD_W-1:0]      out_coord_x,
  output logic [tsfc_pkg::COORD_W-1:0]      out_coord_y,
  output logic                              out_pressed,
  output logic                              out_new_press,
  output logic [tsfc_pkg::COORD_W-1:0]      out_press_start_x,
  output logic [tsfc_pkg::COORD_W-1:0]      out_press_start_y,
  output logic                              out_read_ok
);
  import tsfc_pkg::*;

  // Configuration registers
  logic                       raw_mode_r;
  logic [SAMPLE_W-1:0]        tolerance_r;
  logic signed [GAIN_W-1:0]   x_gain_r, y_gain_r;
  logic signed [OFF_W-1:0]    x_offset_r, y_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r  <= 1'b0;
      tolerance_r <= TOL_RESET;
      x_gain_r    <= '0;
      y_gain_r    <= '0;
      x_offset_r  <= '0;
      y_offset_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAW_MODE:  raw_mode_r  <= cfg_wdata[0];
        CFG_TOLERANCE: tolerance_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_X_GAIN:    x_gain_r    <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_Y_GAIN:    y_gain_r    <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_X_OFFSET:  x_offset_r  <= $signed(cfg_wdata[OFF_W-1:0]);
        CFG_Y_OFFSET:  y_offset_r  <= $signed(cfg_wdata[OFF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage registers
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_v_r;
  logic [1:0]           s1_kind_r, s2_kind_r, s3_kind_r, s4_kind_r, s5_kind_r;
  logic [1:0]           s1_grp_r, s2_grp_r;
  logic [SUM_W-1:0]     s1_sum_r;
  logic [SAMPLE_W-1:0]  s1_min_r, s1_max_r;
  logic [SUM_W-1:0]     s2_num_r;
  logic [SAMPLE_W-1:0]  s3_mean_r;
  logic                 s4_ok_r, s5_ok_r;
  logic [SAMPLE_W-1:0]  s4_rx_r, s4_ry_r, s5_rx_r, s5_ry_r;

  // Handshake: a stage moves when the next one is empty or moving
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, acc;

  assign rdy6 = !out_v_r || !out_stall;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_stall = !rdy1;
  assign acc = in_valid && rdy1;

  // Scan position and group accumulators
  logic [POS_W-1:0]    pos_r;
  logic [1:0]          grp_r;
  logic [SUM_W-1:0]    group_sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] group_min_r, group_max_r, min_nxt, max_nxt;
  logic                pos_last;

  assign sum_nxt  = group_sum_r + SUM_W'(in_sample);
  assign min_nxt  = (in_sample < group_min_r) ? in_sample : group_min_r;
  assign max_nxt  = (in_sample > group_max_r) ? in_sample : group_max_r;
  assign pos_last = (pos_r == POS_W'(SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      grp_r       <= GRP_X1;
      group_sum_r <= '0;
      group_min_r <= SAMPLE_MAX;
      group_max_r <= '0;
    end else if (acc) begin
      if (in_kind == KIND_PEN_UP) begin
        pos_r       <= '0;
        grp_r       <= GRP_X1;
        group_sum_r <= '0;
        group_min_r <= SAMPLE_MAX;
        group_max_r <= '0;
      end else if (in_kind == KIND_SAMPLE) begin
        if (pos_last) begin
          pos_r       <= '0;
          grp_r       <= grp_r + 2'd1;
          group_sum_r <= '0;
          group_min_r <= SAMPLE_MAX;
          group_max_r <= '0;
        end else begin
          pos_r       <= pos_r + POS_W'(1);
          group_sum_r <= sum_nxt;
          group_min_r <= min_nxt;
          group_max_r <= max_nxt;
        end
      end
    end
  end

  // Stage 1: snapshot of a finished group, or a pen-up / acknowledge beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= acc && ((in_kind == KIND_PEN_UP) || (in_kind == KIND_ACK) ||
                        ((in_kind == KIND_SAMPLE) && pos_last));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind_r <= in_kind;
      s1_grp_r  <= grp_r;
      s1_sum_r  <= sum_nxt;
      s1_min_r  <= min_nxt;
      s1_max_r  <= max_nxt;
    end
  end

  // Stage 2: trimmed numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind_r <= s1_kind_r;
      s2_grp_r  <= s1_grp_r;
      s2_num_r  <= s1_sum_r - SUM_W'(s1_min_r) - SUM_W'(s1_max_r);
    end
  end

  // Stage 3: divide by reciprocal multiply; first three means are stored here
  logic [PROD_W-1:0]   quot_prod;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] first_x_mean_r, first_y_mean_r, second_x_mean_r;
  logic                s2_is_grp;

  assign quot_prod = PROD_W'(s2_num_r) * PROD_W'(RECIP);
  assign mean      = quot_prod[QSHIFT +: SAMPLE_W];
  assign s2_is_grp = (s2_kind_r == KIND_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r          <= 1'b0;
      first_x_mean_r  <= '0;
      first_y_mean_r  <= '0;
      second_x_mean_r <= '0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r && (!s2_is_grp || (s2_grp_r == GRP_Y2));
      if (s2_v_r && s2_is_grp) begin
        case (s2_grp_r)
          GRP_X1:  first_x_mean_r  <= mean;
          GRP_Y1:  first_y_mean_r  <= mean;
          GRP_X2:  second_x_mean_r <= mean;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_kind_r <= s2_kind_r;
      s3_mean_r <= mean;
    end
  end

  // Stage 4: agreement check and pair average
  logic [SAMPLE_W-1:0] dx, dy;
  logic [SAMPLE_W:0]   sx, sy;
  logic                agree;

  assign dx = (first_x_mean_r > second_x_mean_r) ? (first_x_mean_r - second_x_mean_r)
                                                 : (second_x_mean_r - first_x_mean_r);
  assign dy = (first_y_mean_r > s3_mean_r) ? (first_y_mean_r - s3_mean_r)
                                           : (s3_mean_r - first_y_mean_r);
  assign sx = {1'b0, first_x_mean_r} + {1'b0, second_x_mean_r};
  assign sy = {1'b0, first_y_mean_r} + {1'b0, s3_mean_r};
  assign agree = (dx < tolerance_r) && (dy < tolerance_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (rdy4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_kind_r <= s3_kind_r;
      s4_ok_r   <= (s3_kind_r == KIND_SAMPLE) && agree;
      s4_rx_r   <= sx[SAMPLE_W:1];
      s4_ry_r   <= sy[SAMPLE_W:1];
    end
  end

  // Stage 5: gain multiply (product registers sit in the scale units)
  logic [COORD_W-1:0] cal_x, cal_y;

  tsfc_scale u_scale_x (
    .clk    (clk),
    .en     (rdy5),
    .raw    (s4_rx_r),
    .gain   (x_gain_r),
    .offset (x_offset_r),
    .coord  (cal_x)
  );

  tsfc_scale u_scale_y (
    .clk    (clk),
    .en     (rdy5),
    .raw    (s4_ry_r),
    .gain   (y_gain_r),
    .offset (y_offset_r),
    .coord  (cal_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (rdy5) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_kind_r <= s4_kind_r;
      s5_ok_r   <= s4_ok_r;
      s5_rx_r   <= s4_rx_r;
      s5_ry_r   <= s4_ry_r;
    end
  end

  // Output stage: coordinate and press state doubles as the result register
  logic [COORD_W-1:0] coord_x_r, coord_y_r, start_x_r, start_y_r;
  logic [COORD_W-1:0] new_x, new_y, upd_x, upd_y;
  logic               pressed_r, new_press_r, read_ok_r;

  assign new_x = raw_mode_r ? COORD_W'(s5_rx_r) : cal_x;
  assign new_y = raw_mode_r ? COORD_W'(s5_ry_r) : cal_y;
  assign upd_x = s5_ok_r ? new_x : coord_x_r;
  assign upd_y = s5_ok_r ? new_y : coord_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      coord_x_r   <= '0;
      coord_y_r   <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      pressed_r   <= 1'b0;
      new_press_r <= 1'b0;
      read_ok_r   <= 1'b0;
    end else if (rdy6) begin
      out_v_r <= s5_v_r;
      if (s5_v_r) begin
        case (s5_kind_r)
          KIND_PEN_UP: begin
            coord_x_r   <= COORD_MAX;
            coord_y_r   <= COORD_MAX;
            pressed_r   <= 1'b0;
            new_press_r <= 1'b0;
            read_ok_r   <= 1'b0;
          end
          KIND_ACK: begin
            new_press_r <= 1'b0;
            read_ok_r   <= 1'b0;
          end
          default: begin
            coord_x_r <= upd_x;
            coord_y_r <= upd_y;
            read_ok_r <= s5_ok_r;
            // first completed scan of a press records the start point
            if (!pressed_r) begin
              pressed_r   <= 1'b1;
              new_press_r <= 1'b1;
              start_x_r   <= upd_x;
              start_y_r   <= upd_y;
            end
          end
        endcase
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_coord_x       = coord_x_r;
  assign out_coord_y       = coord_y_r;
  assign out_pressed       = pressed_r;
  assign out_new_press     = new_press_r;
  assign out_press_start_x = start_x_r;
  assign out_press_start_y = start_y_r;
  assign out_read_ok       = read_ok_r;

endmodule

/* verif/tsfc_report_checker.sv */
// Result checker for the touch sample filter: tracks config, predicts each report, compares.
`timescale 1ns / 1ps

module tsfc_report_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsfc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tsfc_pkg::COORD_W-1:0]   out_coord_x,
  input  logic [tsfc_pkg::COORD_W-1:0]   out_coord_y,
  input  logic                           out_pressed,
  input  logic                           out_new_press,
  input  logic [tsfc_pkg::COORD_W-1:0]   out_press_start_x,
  input  logic [tsfc_pkg::COORD_W-1:0]   out_press_start_y,
  input  logic                           out_read_ok,
  output int                             mismatches,
  output int                             pending
);
  import tsfc_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pressed;
    logic               new_press;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic               read_ok;
  } touch_report_t;

  touch_report_t reports_due[$];
  int fail_total = 0;

  // register copies
  logic                     cal_bypass;
  logic [SAMPLE_W-1:0]      agree_tol;
  logic signed [GAIN_W-1:0] gain_x, gain_y;
  logic signed [OFF_W-1:0]  off_x, off_y;

  // scan state
  int                  smp_count;
  logic [SUM_W-1:0]    acc_sum;
  logic [SAMPLE_W-1:0] acc_lo, acc_hi;
  logic [SAMPLE_W-1:0] mean_x1, mean_y1, mean_x2;
  logic [COORD_W-1:0]  cur_x, cur_y, start_x, start_y;
  logic                pen_down, fresh_press;

  function automatic int spread12(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Q3.14 gain plus pixel offset, negative floors at zero, top saturates
  function automatic logic [COORD_W-1:0] apply_gain(logic [SAMPLE_W-1:0] raw,
                                                    logic signed [GAIN_W-1:0] g,
                                                    logic signed [OFF_W-1:0] o);
    longint v;
    v = longint'(g) * longint'(raw) + longint'(o) * (longint'(1) <<< FRAC_W);
    if (v < 0) return '0;
    v = v >>> FRAC_W;
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    return COORD_W'(v);
  endfunction

  function automatic touch_report_t snapshot(logic ok);
    touch_report_t r;
    r.x         = cur_x;
    r.y         = cur_y;
    r.pressed   = pen_down;
    r.new_press = fresh_press;
    r.start_x   = start_x;
    r.start_y   = start_y;
    r.read_ok   = ok;
    return r;
  endfunction

  task automatic clear_acc();
    acc_sum = '0;
    acc_lo  = SAMPLE_MAX;
    acc_hi  = '0;
  endtask

  // one accepted input beat -> state update and maybe one expected report
  task automatic predict_touch_beat(logic [1:0] kind, logic [SAMPLE_W-1:0] smp);
    logic [1:0]          grp;
    logic                last;
    logic [SUM_W-1:0]    span;
    logic [SUM_W-1:0]    quot;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W:0]   pair_x, pair_y;
    logic                agree;
    case (kind)
      KIND_PEN_UP: begin
        pen_down    = 1'b0;
        fresh_press = 1'b0;
        cur_x       = COORD_MAX;
        cur_y       = COORD_MAX;
        smp_count   = 0;
        clear_acc();
        reports_due.push_back(snapshot(1'b0));
      end
      KIND_ACK: begin
        fresh_press = 1'b0;
        reports_due.push_back(snapshot(1'b0));
      end
      KIND_SAMPLE: begin
        if (smp_count >= 4 * SAMPLES) smp_count = 0;
        acc_sum = acc_sum + SUM_W'(smp);
        if (smp < acc_lo) acc_lo = smp;
        if (smp > acc_hi) acc_hi = smp;
        grp  = 2'(smp_count / SAMPLES);
        last = (smp_count % SAMPLES) == SAMPLES - 1;
        smp_count++;
        if (last) begin
          // trimmed mean: drop one low and one high sample
          span = acc_sum - SUM_W'(acc_lo) - SUM_W'(acc_hi);
          quot = span / SUM_W'(DIV);
          mean = quot[SAMPLE_W-1:0];
          clear_acc();
          case (grp)
            GRP_X1: mean_x1 = mean;
            GRP_Y1: mean_y1 = mean;
            GRP_X2: mean_x2 = mean;
            GRP_Y2: begin
              smp_count = 0;
              agree = spread12(mean_x1, mean_x2) < int'(agree_tol) &&
                      spread12(mean_y1, mean) < int'(agree_tol);
              if (agree) begin
                pair_x = ({1'b0, mean_x1} + {1'b0, mean_x2}) >> 1;
                pair_y = ({1'b0, mean_y1} + {1'b0, mean}) >> 1;
                if (cal_bypass) begin
                  cur_x = COORD_W'(pair_x[SAMPLE_W-1:0]);
                  cur_y = COORD_W'(pair_y[SAMPLE_W-1:0]);
                end else begin
                  cur_x = apply_gain(pair_x[SAMPLE_W-1:0], gain_x, off_x);
                  cur_y = apply_gain(pair_y[SAMPLE_W-1:0], gain_y, off_y);
                end
              end
              // first report of a press latches the start point
              if (!pen_down) begin
                pen_down    = 1'b1;
                fresh_press = 1'b1;
                start_x     = cur_x;
                start_y     = cur_y;
              end
              reports_due.push_back(snapshot(agree));
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_total++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    touch_report_t want;
    if (!rst_n) begin
      cal_bypass  = 1'b0;
      agree_tol   = TOL_RESET;
      gain_x      = '0;
      gain_y      = '0;
      off_x       = '0;
      off_y       = '0;
      smp_count   = 0;
      clear_acc();
      mean_x1     = '0;
      mean_y1     = '0;
      mean_x2     = '0;
      cur_x       = '0;
      cur_y       = '0;
      start_x     = '0;
      start_y     = '0;
      pen_down    = 1'b0;
      fresh_press = 1'b0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAW_MODE:  cal_bypass = cfg_wdata[0];
          CFG_TOLERANCE: agree_tol  = cfg_wdata[SAMPLE_W-1:0];
          CFG_X_GAIN:    gain_x     = cfg_wdata[GAIN_W-1:0];
          CFG_Y_GAIN:    gain_y     = cfg_wdata[GAIN_W-1:0];
          CFG_X_OFFSET:  off_x      = cfg_wdata[OFF_W-1:0];
          CFG_Y_OFFSET:  off_y      = cfg_wdata[OFF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_touch_beat(in_kind, in_sample);
      // compare the result beat with the oldest report due
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result beat: expected none, got x=%0d y=%0d ok=%0d",
                   $time, out_coord_x, out_coord_y, out_read_ok);
        end else begin
          want = reports_due.pop_front();
          check_field("coord_x", want.x, out_coord_x);
          check_field("coord_y", want.y, out_coord_y);
          check_field("pressed", want.pressed, out_pressed);
          check_field("new_press", want.new_press, out_new_press);
          check_field("press_start_x", want.start_x, out_press_start_x);
          check_field("press_start_y", want.start_y, out_press_start_y);
          check_field("read_ok", want.read_ok, out_read_ok);
        end
      end
    end
    mismatches <= fail_total;
    pending    <= reports_due.size();
  end

endmodule

/* verif/touch_sample_filter_calibrator_test.sv */
// Testbench top for the touch sample filter: clock, reset, stimulus, stall control, verdict.
`timescale 1ns / 1ps

module touch_sample_filter_calibrator_test;
  import tsfc_pkg::*;

  localparam logic [1:0]              KIND_UNUSED = 2'd3;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 18'sh1FFFF;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN   = 18'sh20000;
  localparam logic signed [OFF_W-1:0]  OFF_MAX    = 16'sh7FFF;
  localparam logic signed [OFF_W-1:0]  OFF_MIN    = 16'sh8000;
  localparam int LATENCY     = 5;
  localparam int LONG_HOLD   = 200;
  localparam int PHASE_BEATS = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind = KIND_SAMPLE;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_coord_x, out_coord_y;
  logic                 out_pressed, out_new_press;
  logic [COORD_W-1:0]   out_press_start_x, out_press_start_y;
  logic                 out_read_ok;

  int mismatches;
  int pending;
  int items_sent = 0;
  int send_run = 0;
  int cycle_count = 0;
  int long_hold_reqs = 0;

  touch_sample_filter_calibrator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .out_pressed(out_pressed), .out_new_press(out_new_press),
    .out_press_start_x(out_press_start_x), .out_press_start_y(out_press_start_y),
    .out_read_ok(out_read_ok)
  );

  tsfc_report_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .out_pressed(out_pressed), .out_new_press(out_new_press),
    .out_press_start_x(out_press_start_x), .out_press_start_y(out_press_start_y),
    .out_read_ok(out_read_ok),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_sample_filter_calibrator_test: FAIL");
      $finish;
    end
  end

  // receiver: random stall per result beat, bursts with none, one long hold on request
  initial begin
    int hold;
    int run;
    int holds_done;
    run = 0;
    holds_done = 0;
    forever begin
      if (long_hold_reqs > holds_done) begin
        holds_done++;
        hold = LONG_HOLD;
      end else if (run > 0) begin
        hold = 0;
        run--;
      end else begin
        hold = $urandom_range(0, 6);
        if ($urandom_range(0, 15) == 0) run = $urandom_range(10, 40);
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input beat, preceded by a random gap
  task automatic send_beat(logic [1:0] kind, logic [SAMPLE_W-1:0] smp);
    int gap;
    if (send_run > 0) begin
      gap = 0;
      send_run--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) send_run = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // wait for every report, then let any sample still in the pipe retire
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY * 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic set_regs(logic raw, logic [SAMPLE_W-1:0] tol,
                          logic signed [GAIN_W-1:0] xg, logic signed [GAIN_W-1:0] yg,
                          logic signed [OFF_W-1:0] xo, logic signed [OFF_W-1:0] yo);
    write_reg(CFG_RAW_MODE, CFG_W'(raw));
    write_reg(CFG_TOLERANCE, CFG_W'(tol));
    write_reg(CFG_X_GAIN, xg);
    write_reg(CFG_Y_GAIN, yg);
    write_reg(CFG_X_OFFSET, {{(CFG_W - OFF_W){xo[OFF_W-1]}}, xo});
    write_reg(CFG_Y_OFFSET, {{(CFG_W - OFF_W){yo[OFF_W-1]}}, yo});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] jitter(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  function automatic int pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return SAMPLE_MAX;
    return $urandom_range(0, SAMPLE_MAX);
  endfunction

  // one group of samples, now and then with an ack or an unused kind slipped in
  task automatic send_group(int base, int spread);
    for (int i = 0; i < SAMPLES; i++) begin
      if ($urandom_range(0, 39) == 0)
        send_beat($urandom_range(0, 1) ? KIND_ACK : KIND_UNUSED, SAMPLE_W'($urandom));
      send_beat(KIND_SAMPLE, jitter(base, spread));
    end
  endtask

  // full X, Y, X, Y scan; second pass drifts by a small or a large step
  task automatic send_scan();
    int bx, by, spread, drift;
    bx     = pick_base();
    by     = pick_base();
    spread = ($urandom_range(0, 4) == 0) ? int'(SAMPLE_MAX) : $urandom_range(0, 8);
    drift  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
    send_group(bx, spread);
    send_group(by, spread);
    send_group(jitter(bx, drift), spread);
    send_group(jitter(by, drift), spread);
  endtask

  task automatic run_traffic(int budget);
    int goal, pick, cut;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_scan();
      end else if (pick < 78) begin
        // scan cut short by pen-up
        cut = $urandom_range(1, 4 * SAMPLES - 1);
        repeat (cut) send_beat(KIND_SAMPLE, SAMPLE_W'($urandom));
        send_beat(KIND_PEN_UP, SAMPLE_W'($urandom));
      end else if (pick < 86) begin
        send_beat(KIND_ACK, SAMPLE_W'($urandom));
      end else if (pick < 92) begin
        send_beat(KIND_PEN_UP, SAMPLE_W'($urandom));
      end else if (pick < 96) begin
        send_beat(KIND_UNUSED, SAMPLE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_beat(KIND_SAMPLE, SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: unused kind, pen-up, a scan at the sample extremes with an ack
    // and an unused kind mid-scan, ack after the press, partial scan aborted
    send_beat(KIND_UNUSED, SAMPLE_MAX);
    send_beat(KIND_PEN_UP, '0);
    repeat (SAMPLES) send_beat(KIND_SAMPLE, SAMPLE_MAX);
    send_beat(KIND_SAMPLE, '0);
    send_beat(KIND_SAMPLE, SAMPLE_MAX);
    send_beat(KIND_ACK, '0);
    send_beat(KIND_UNUSED, '0);
    for (int i = 2; i < SAMPLES; i++) send_beat(KIND_SAMPLE, (i % 2) ? SAMPLE_MAX : '0);
    repeat (SAMPLES) send_beat(KIND_SAMPLE, SAMPLE_MAX);
    for (int i = 0; i < SAMPLES; i++) send_beat(KIND_SAMPLE, (i % 2) ? SAMPLE_MAX : '0);
    send_beat(KIND_ACK, '0);
    send_beat(KIND_SAMPLE, 12'h555);
    send_beat(KIND_SAMPLE, 12'hAAA);
    send_beat(KIND_PEN_UP, '0);

    // random phases, each under its own register setting
    for (int phase = 1; phase <= 5; phase++) begin
      drain();
      case (phase)
        1: set_regs(1'b1, SAMPLE_MAX, GAIN_W'($urandom), GAIN_W'($urandom),
                    OFF_W'($urandom), OFF_W'($urandom));
        2: set_regs(1'b0, SAMPLE_MAX, GAIN_MAX, GAIN_MIN, OFF_MIN, OFF_MAX);
        3: set_regs(1'b0, SAMPLE_W'($urandom_range(20, 200)), GAIN_MIN, GAIN_MAX,
                    OFF_MAX, OFF_MIN);
        4: set_regs(1'b0, '0, GAIN_W'($urandom_range(0, 131071)),
                    GAIN_W'($urandom_range(0, 131071)), OFF_W'($urandom), OFF_W'($urandom));
        default: set_regs(1'($urandom), SAMPLE_W'($urandom), GAIN_W'($urandom),
                          GAIN_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
      endcase
      if (phase == 1) begin
        // receiver holds off while acks keep coming, so the pipe fills
        long_hold_reqs++;
        repeat (40) send_beat(KIND_ACK, SAMPLE_W'($urandom));
      end
      if (phase == 3) begin
        run_traffic(PHASE_BEATS / 2);
        drain();
        run_traffic(PHASE_BEATS / 2);
      end else begin
        run_traffic(PHASE_BEATS);
      end
    end

    drain();
    if (mismatches == 0)
      $display("touch_sample_filter_calibrator_test: PASS");
    else
      $display("touch_sample_filter_calibrator_test: FAIL");
    $finish;
  end

endmodule

/* touch_sample_filter_calibrator.f */
sv/tsfc_pkg.sv
sv/tsfc_scale.sv
sv/touch_sample_filter_calibrator.sv
verif/tsfc_report_checker.sv
verif/touch_sample_filter_calibrator_test.sv
